[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the autofocus sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is disabled while reset is asserted.
`define AFSC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define AFSC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/afsc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Autofocus sequencer package
// Types, register indexes and widths shared by the autofocus sequencer.
// ----------------------------------------------------------------------------
package afsc_pkg;

    localparam int STEP_BITS = 10;
    localparam int CNT_BITS  = 9;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [CNT_BITS-1:0] CNT_ONE = CNT_BITS'(1);

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_MEAS    = 3'd1,
        ST_MOVE    = 3'd2,
        ST_SETTLE  = 3'd3,
        ST_VERIFY  = 3'd4,
        ST_FOCUSED = 3'd5,
        ST_FAILED  = 3'd6
    } t_state;

    typedef enum logic {
        REQ_TRIGGER = 1'b0,
        REQ_FRAME   = 1'b1
    } t_req;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_CONF_THRESHOLD = 2'd0,
        CFG_DISP_LIMIT     = 2'd1,
        CFG_RETRY_LIMIT    = 2'd2,
        CFG_ITER_LIMIT     = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] min_confidence;
        logic [14:0] focus_disparity_limit;
        logic [7:0]  retry_limit;
        logic [7:0]  iteration_limit;
    } t_cfg;

    typedef struct packed {
        t_state                focus_state;
        logic [CNT_BITS-1:0]   retry_count;
        logic [CNT_BITS-1:0]   iteration_count;
        logic [STEP_BITS-1:0]  target_position;
    } t_ctx;

    typedef struct packed {
        logic                  req_type;
        logic [15:0]           frame_number;
        logic [STEP_BITS-1:0]  lens_position_now;
        logic                  lens_busy;
        logic                  estimate_valid;
        logic [15:0]           estimate_confidence;
        logic signed [15:0]    estimate_disparity;
        logic [STEP_BITS-1:0]  mapped_target;
    } t_in_item;

    typedef struct packed {
        logic [15:0]           log_frame;
        logic [2:0]            state_prior;
        logic [2:0]            state_next;
        logic [STEP_BITS-1:0]  log_lens_position;
        logic [STEP_BITS-1:0]  log_target;
        logic signed [15:0]    log_disparity;
        logic [15:0]           log_confidence;
        logic                  move_request;
    } t_out_item;

endpackage

[src/afsc_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Autofocus request channel
// Valid/ready channel carrying trigger and frame transactions.
// ----------------------------------------------------------------------------
interface afsc_req_if;
    logic                            valid;
    logic                            ready;
    logic                            req_type;
    logic [15:0]                     frame_number;
    logic [afsc_pkg::STEP_BITS-1:0]  lens_position_now;
    logic                            lens_busy;
    logic                            estimate_valid;
    logic [15:0]                     estimate_confidence;
    logic signed [15:0]              estimate_disparity;
    logic [afsc_pkg::STEP_BITS-1:0]  mapped_target;

    modport source (
        output valid, req_type, frame_number, lens_position_now, lens_busy,
               estimate_valid, estimate_confidence, estimate_disparity, mapped_target,
        input  ready
    );

    modport sink (
        input  valid, req_type, frame_number, lens_position_now, lens_busy,
               estimate_valid, estimate_confidence, estimate_disparity, mapped_target,
        output ready
    );
endinterface

[src/afsc_log_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Autofocus log channel
// Valid/ready channel carrying one log transaction per frame.
// ----------------------------------------------------------------------------
interface afsc_log_if;
    logic                            valid;
    logic                            ready;
    logic [15:0]                     log_frame;
    logic [2:0]                      state_prior;
    logic [2:0]                      state_next;
    logic [afsc_pkg::STEP_BITS-1:0]  log_lens_position;
    logic [afsc_pkg::STEP_BITS-1:0]  log_target;
    logic signed [15:0]              log_disparity;
    logic [15:0]                     log_confidence;
    logic                            move_request;

    modport source (
        output valid, log_frame, state_prior, state_next, log_lens_position,
               log_target, log_disparity, log_confidence, move_request,
        input  ready
    );

    modport sink (
        input  valid, log_frame, state_prior, state_next, log_lens_position,
               log_target, log_disparity, log_confidence, move_request,
        output ready
    );
endinterface

[src/afsc_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Autofocus sequencer step
// Combinational next-state, counter and log logic for one transaction.
// ----------------------------------------------------------------------------
module afsc_step (
    input  afsc_pkg::t_ctx      i_ctx,
    input  afsc_pkg::t_cfg      i_cfg,
    input  afsc_pkg::t_in_item  i_item,
    output afsc_pkg::t_ctx      o_ctx,
    output afsc_pkg::t_out_item o_res
);

    logic                             is_frame;
    logic                             restart;
    logic                             judging;
    logic                             low_conf;
    logic                             near_focus;
    logic [14:0]                      abs_disp;
    logic [afsc_pkg::CNT_BITS-1:0]    retry_inc;
    logic [afsc_pkg::CNT_BITS-1:0]    iter_inc;
    logic                             retry_fail;
    logic                             iter_fail;
    logic                             issue_move;
    afsc_pkg::t_state                 n_state;

    assign is_frame = (i_item.req_type == afsc_pkg::REQ_FRAME);
    assign restart  = !is_frame && ((i_ctx.focus_state == afsc_pkg::ST_IDLE)
                      || (i_ctx.focus_state == afsc_pkg::ST_FOCUSED)
                      || (i_ctx.focus_state == afsc_pkg::ST_FAILED));
    assign judging  = is_frame && ((i_ctx.focus_state == afsc_pkg::ST_MEAS)
                      || (i_ctx.focus_state == afsc_pkg::ST_VERIFY));
    assign low_conf = !i_item.estimate_valid
                      || (i_item.estimate_confidence < i_cfg.min_confidence);

    // The most negative disparity saturates to the largest magnitude.
    always_comb begin
        if (!i_item.estimate_disparity[15]) begin
            abs_disp = i_item.estimate_disparity[14:0];
        end else if (i_item.estimate_disparity[14:0] == 15'd0) begin
            abs_disp = '1;
        end else begin
            abs_disp = 15'(-i_item.estimate_disparity);
        end
    end

    assign near_focus = (abs_disp < i_cfg.focus_disparity_limit);
    assign retry_inc  = (i_ctx.retry_count == afsc_pkg::CNT_MAX)
                        ? i_ctx.retry_count : i_ctx.retry_count + afsc_pkg::CNT_ONE;
    assign iter_inc   = (i_ctx.iteration_count == afsc_pkg::CNT_MAX)
                        ? i_ctx.iteration_count : i_ctx.iteration_count + afsc_pkg::CNT_ONE;
    assign retry_fail = (retry_inc > {1'b0, i_cfg.retry_limit});
    assign iter_fail  = (iter_inc > {1'b0, i_cfg.iteration_limit});
    assign issue_move = judging && !low_conf && !near_focus && !iter_fail;

    always_comb begin
        n_state = i_ctx.focus_state;
        if (!is_frame) begin
            if (restart) begin
                n_state = afsc_pkg::ST_MEAS;
            end
        end else begin
            case (i_ctx.focus_state)
                afsc_pkg::ST_MOVE, afsc_pkg::ST_SETTLE: begin
                    n_state = i_item.lens_busy ? afsc_pkg::ST_SETTLE : afsc_pkg::ST_VERIFY;
                end
                afsc_pkg::ST_MEAS, afsc_pkg::ST_VERIFY: begin
                    if (low_conf) begin
                        if (retry_fail) begin
                            n_state = afsc_pkg::ST_FAILED;
                        end
                    end else if (near_focus) begin
                        n_state = afsc_pkg::ST_FOCUSED;
                    end else if (iter_fail) begin
                        n_state = afsc_pkg::ST_FAILED;
                    end else begin
                        n_state = afsc_pkg::ST_MOVE;
                    end
                end
                default: begin
                    n_state = i_ctx.focus_state;
                end
            endcase
        end
    end

    always_comb begin
        o_ctx             = i_ctx;
        o_ctx.focus_state = n_state;
        if (restart) begin
            o_ctx.retry_count     = '0;
            o_ctx.iteration_count = '0;
        end else if (judging) begin
            if (low_conf) begin
                o_ctx.retry_count = retry_inc;
            end else begin
                o_ctx.retry_count = '0;
                if (!near_focus) begin
                    o_ctx.iteration_count = iter_inc;
                end
            end
        end
        if (issue_move) begin
            o_ctx.target_position = i_item.mapped_target;
        end
    end

    always_comb begin
        o_res.log_frame         = i_item.frame_number;
        o_res.state_prior       = i_ctx.focus_state;
        o_res.state_next        = n_state;
        o_res.log_lens_position = i_item.lens_position_now;
        o_res.log_target        = issue_move ? i_item.mapped_target : i_ctx.target_position;
        o_res.move_request      = issue_move;
        if (judging && i_item.estimate_valid) begin
            o_res.log_disparity  = i_item.estimate_disparity;
            o_res.log_confidence = i_item.estimate_confidence;
        end else begin
            o_res.log_disparity  = '0;
            o_res.log_confidence = '0;
        end
    end

endmodule

[src/autofocus_sequence_control.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Autofocus sequence control
// Phase-detect autofocus sequencer with a registered request stage and a
// registered log output.
// ----------------------------------------------------------------------------
// A request transaction is taken into an input register and judged from it
// against the sequencer state, so the block accepts one transaction every
// cycle unless stalled; a frame's log transaction is registered in the log
// output register as the frame is judged. The rate is set by the single
// request register and the log output register; the block stalls only while a
// finished log transaction waits on the output and the next frame needs that
// register. Trigger transactions produce no log. Configuration writes take effect at once.
`include "assert_macros.svh"

module autofocus_sequence_control (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [afsc_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [afsc_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    afsc_req_if.sink                              i_req,
    afsc_log_if.source                            o_log
);

    afsc_pkg::t_cfg      r_cfg;
    afsc_pkg::t_ctx      r_ctx;
    afsc_pkg::t_ctx      n_ctx;
    afsc_pkg::t_in_item  r_item;
    afsc_pkg::t_in_item  in_item;
    afsc_pkg::t_out_item r_out;
    afsc_pkg::t_out_item n_out;
    logic                r_item_valid;
    logic                r_out_valid;
    logic                item_is_frame;
    logic                advance;
    logic                take;

    assign in_item.req_type            = i_req.req_type;
    assign in_item.frame_number        = i_req.frame_number;
    assign in_item.lens_position_now   = i_req.lens_position_now;
    assign in_item.lens_busy           = i_req.lens_busy;
    assign in_item.estimate_valid      = i_req.estimate_valid;
    assign in_item.estimate_confidence = i_req.estimate_confidence;
    assign in_item.estimate_disparity  = i_req.estimate_disparity;
    assign in_item.mapped_target       = i_req.mapped_target;

    assign item_is_frame = (r_item.req_type == afsc_pkg::REQ_FRAME);
    assign advance       = r_item_valid && (!item_is_frame || !r_out_valid || o_log.ready);
    assign i_req.ready   = !r_item_valid || advance;
    assign take          = i_req.valid && i_req.ready;

    afsc_step u_step (
        .i_ctx  (r_ctx),
        .i_cfg  (r_cfg),
        .i_item (r_item),
        .o_ctx  (n_ctx),
        .o_res  (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_confidence        <= 16'd32768;
            r_cfg.focus_disparity_limit <= 15'd128;
            r_cfg.retry_limit           <= 8'd3;
            r_cfg.iteration_limit       <= 8'd5;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                afsc_pkg::CFG_CONF_THRESHOLD: r_cfg.min_confidence        <= i_cfg_data;
                afsc_pkg::CFG_DISP_LIMIT:     r_cfg.focus_disparity_limit <= i_cfg_data[14:0];
                afsc_pkg::CFG_RETRY_LIMIT:    r_cfg.retry_limit           <= i_cfg_data[7:0];
                afsc_pkg::CFG_ITER_LIMIT:     r_cfg.iteration_limit       <= i_cfg_data[7:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx.focus_state     <= afsc_pkg::ST_IDLE;
            r_ctx.retry_count     <= '0;
            r_ctx.iteration_count <= '0;
            r_ctx.target_position <= '0;
            r_item_valid          <= 1'b0;
            r_out_valid           <= 1'b0;
        end else begin
            if (advance) begin
                r_ctx <= n_ctx;
            end
            if (take) begin
                r_item_valid <= 1'b1;
            end else if (advance) begin
                r_item_valid <= 1'b0;
            end
            if (advance && item_is_frame) begin
                r_out_valid <= 1'b1;
            end else if (o_log.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= in_item;
        end
        if (advance && item_is_frame) begin
            r_out <= n_out;
        end
    end

    assign o_log.valid             = r_out_valid;
    assign o_log.log_frame         = r_out.log_frame;
    assign o_log.state_prior       = r_out.state_prior;
    assign o_log.state_next        = r_out.state_next;
    assign o_log.log_lens_position = r_out.log_lens_position;
    assign o_log.log_target        = r_out.log_target;
    assign o_log.log_disparity     = r_out.log_disparity;
    assign o_log.log_confidence    = r_out.log_confidence;
    assign o_log.move_request      = r_out.move_request;

    `AFSC_ASSERT(a_stall_holds_frame, i_clk, i_rst_n, (r_item_valid && item_is_frame && r_out_valid && !o_log.ready) |=> r_item_valid, "Stalled frame left the request register.")
    `AFSC_ASSERT(a_move_enters_moving, i_clk, i_rst_n, (r_out_valid && r_out.move_request) |-> (r_out.state_next == afsc_pkg::ST_MOVE), "Move issued without entering the moving state.")
    `AFSC_ASSERT(a_retry_bounded, i_clk, i_rst_n, (r_ctx.retry_count <= 9'd256) && (r_ctx.iteration_count <= 9'd256), "Sequencer counter ran past its limit range.")
    `AFSC_ASSERT_ALWAYS(a_reset_empty, i_clk, $past(!i_rst_n) |-> (!r_out_valid && !r_item_valid), "Pipeline not empty after reset.")

endmodule
